>>> rtl/hri_pkg.sv
// Shared types and constants for the Halton radical inverse block.
package hri_pkg;

  localparam int unsigned RADIX_W   = 8;
  localparam int unsigned IN_W      = 32;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned RADIX_MIN = 2;
  localparam int unsigned RADIX_RST = 2;

  typedef logic [RADIX_W-1:0] radix_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_ACC,
    ST_FRAC
  } state_t;

endpackage

>>> rtl/hri_divstep.sv
// Shared restoring division step: one compare and conditional subtract.
module hri_divstep #(
  parameter int unsigned W = 41
) (
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] div_in,
  output logic [W-1:0] rem_out,
  output logic         q_bit
);

  always_comb begin
    q_bit   = (rem_in >= div_in);
    rem_out = q_bit ? (rem_in - div_in) : rem_in;
  end

endmodule

>>> rtl/halton_radical_inverse_top.sv
// Top level of the Halton radical inverse unit with its digit and fraction sequencer.
//
//   channel   ports                                    handshake
//   config    cfg_we, cfg_data                         write when cfg_we is high
//   input     start, in_index, busy                    accepted when start and not busy
//   result    out_valid, out_value, out_digit_count    one-cycle strobe on out_valid
//
// A word with n base digits passes n times through ST_DIGIT and ST_ACC and then through
// ST_FRAC before its strobe; index zero goes from acceptance straight to ST_FRAC.
// Every quotient bit of every digit and of the fraction passes through the one shared
// compare and subtract unit, one bit per cycle while in ST_DIGIT or ST_FRAC.
// busy stays high until the result strobe, which is held for exactly one cycle.
// Reset is synchronous and active low and returns the radix to two.
module halton_radical_inverse_top #(
  parameter int unsigned INDEX_WIDTH    = 32,
  parameter int unsigned FRACTION_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hri_pkg::RADIX_W-1:0]     cfg_data,
  input  logic                            start,
  input  logic [hri_pkg::IN_W-1:0]        in_index,
  output logic                            busy,
  output logic                            out_valid,
  output logic [hri_pkg::OUT_W-1:0]       out_value,
  output logic [hri_pkg::CNT_W-1:0]       out_digit_count
);

  localparam int unsigned DW       = INDEX_WIDTH + hri_pkg::RADIX_W;
  localparam int unsigned UW       = DW + 1;
  localparam int unsigned PW       = DW + hri_pkg::RADIX_W;
  localparam int unsigned LOOP_MAX = (INDEX_WIDTH > FRACTION_WIDTH) ? INDEX_WIDTH
                                                                    : FRACTION_WIDTH;
  localparam int unsigned BW       = $clog2(LOOP_MAX + 1);

  hri_pkg::state_t state_r, state_nxt;
  hri_pkg::radix_t radix_r;
  hri_pkg::radix_t radix_eff;

  logic [INDEX_WIDTH-1:0]      idx_r, idx_nxt;
  logic [DW-1:0]               rem_r, rem_nxt;
  logic [DW-1:0]               mir_r, mir_nxt;
  logic [DW-1:0]               den_r, den_nxt;
  logic [FRACTION_WIDTH-1:0]   quo_r, quo_nxt;
  logic [hri_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BW-1:0]               bit_r, bit_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [hri_pkg::OUT_W-1:0]   out_value_r, out_value_nxt;
  logic [hri_pkg::CNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic [UW-1:0]               step_rem;
  logic [UW-1:0]               step_div;
  logic [UW-1:0]               step_out;
  logic                        step_q;
  logic [PW-1:0]               mir_prod;
  logic [PW-1:0]               den_prod;
  logic [FRACTION_WIDTH-1:0]   quo_fin;
  logic [FRACTION_WIDTH+hri_pkg::OUT_W-1:0] quo_ext;

  assign radix_eff = (radix_r < hri_pkg::radix_t'(hri_pkg::RADIX_MIN))
                     ? hri_pkg::radix_t'(hri_pkg::RADIX_MIN) : radix_r;

  always_comb begin
    if (state_r == hri_pkg::ST_FRAC) begin
      step_rem = {rem_r, 1'b0};
      step_div = {1'b0, den_r};
    end else begin
      step_rem = {rem_r, idx_r[INDEX_WIDTH-1]};
      step_div = UW'(radix_eff);
    end
  end

  hri_divstep #(
    .W (UW)
  ) u_divstep (
    .rem_in  (step_rem),
    .div_in  (step_div),
    .rem_out (step_out),
    .q_bit   (step_q)
  );

  assign mir_prod = PW'(mir_r) * PW'(radix_eff);
  assign den_prod = PW'(den_r) * PW'(radix_eff);
  assign quo_fin  = {quo_r[FRACTION_WIDTH-2:0], step_q};
  assign quo_ext  = {{hri_pkg::OUT_W{1'b0}}, quo_fin};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hri_pkg::ST_IDLE;
      radix_r     <= hri_pkg::radix_t'(hri_pkg::RADIX_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        radix_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    rem_r       <= rem_nxt;
    mir_r       <= mir_nxt;
    den_r       <= den_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    bit_r       <= bit_nxt;
    out_value_r <= out_value_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    mir_nxt       = mir_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    bit_nxt       = bit_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_cnt_nxt   = out_cnt_r;
    case (state_r)
      hri_pkg::ST_IDLE: begin
        if (start) begin
          idx_nxt = in_index[INDEX_WIDTH-1:0];
          rem_nxt = '0;
          mir_nxt = '0;
          den_nxt = DW'(1);
          quo_nxt = '0;
          cnt_nxt = '0;
          bit_nxt = '0;
          if (in_index[INDEX_WIDTH-1:0] == '0) begin
            state_nxt = hri_pkg::ST_FRAC;
          end else begin
            state_nxt = hri_pkg::ST_DIGIT;
          end
        end
      end
      hri_pkg::ST_DIGIT: begin
        rem_nxt = step_out[DW-1:0];
        idx_nxt = {idx_r[INDEX_WIDTH-2:0], step_q};
        bit_nxt = bit_r + BW'(1);
        if (bit_r == BW'(INDEX_WIDTH - 1)) begin
          state_nxt = hri_pkg::ST_ACC;
        end
      end
      hri_pkg::ST_ACC: begin
        mir_nxt = mir_prod[DW-1:0] + rem_r;
        den_nxt = den_prod[DW-1:0];
        cnt_nxt = cnt_r + hri_pkg::CNT_W'(1);
        bit_nxt = '0;
        if (idx_r == '0) begin
          rem_nxt   = mir_prod[DW-1:0] + rem_r;
          state_nxt = hri_pkg::ST_FRAC;
        end else begin
          rem_nxt   = '0;
          state_nxt = hri_pkg::ST_DIGIT;
        end
      end
      hri_pkg::ST_FRAC: begin
        rem_nxt = step_out[DW-1:0];
        quo_nxt = quo_fin;
        bit_nxt = bit_r + BW'(1);
        if (bit_r == BW'(FRACTION_WIDTH - 1)) begin
          state_nxt     = hri_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          out_value_nxt = quo_ext[hri_pkg::OUT_W-1:0];
          out_cnt_nxt   = cnt_r;
        end
      end
      default: begin
        state_nxt = hri_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != hri_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_digit_count = out_cnt_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a word is still in progress");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_count <= hri_pkg::CNT_W'(INDEX_WIDTH)))
    else $error("digit count exceeds index width");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_digit_count == '0)) |-> (out_value == '0))
    else $error("index zero gave a nonzero value");

endmodule
